// File: hw/rtl/bgus_pkg.sv
// Shared types and constants of the buddy group upload scheduler.
package bgus_pkg;

	// Item kinds on the input stream
	typedef enum logic [1:0] {
		FN_REPORT = 2'd0,
		FN_TICK   = 2'd1,
		FN_DONE   = 2'd2,
		FN_RSVD   = 2'd3
	} func_t;

	// Reply kinds on the output stream
	typedef enum logic [1:0] {
		ACT_SKIP   = 2'd0,
		ACT_WAIT   = 2'd1,
		ACT_UPLOAD = 2'd2,
		ACT_ACK    = 2'd3
	} action_t;

	// Configuration register indexes
	localparam logic REG_MAX_BUF  = 1'b0;
	localparam logic REG_INTERVAL = 1'b1;

	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 64;
	localparam int BYTES_W     = 36;
	localparam int MASK_W      = 16;
	localparam int ACTIVE_W    = 5;
	localparam int TIME_W      = 32;

	localparam logic [31:0] MAX_BUF_RESET  = 32'd4194304;
	localparam logic [15:0] INTERVAL_RESET = 16'd250;

	// Field write enables of the shard table
	typedef struct packed {
		logic grp;
		logic cnt;
	} sm_we_t;

	// Field write enables of the group table
	typedef struct packed {
		logic turn;
		logic lu;
		logic lc;
		logic lock;
	} gm_we_t;

endpackage

// File: hw/rtl/bgus_shard_mem.sv
// Shard table: group id, backlog and next-stage bytes per shard.
module bgus_shard_mem #(
	parameter int SHARDS = 16,
	parameter int SW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [SW-1:0]        raddr,
	output logic [SW-1:0]        rgrp,
	output logic [31:0]          rbl,
	output logic [31:0]          rnx,
	input  logic [SW-1:0]        waddr,
	input  bgus_pkg::sm_we_t     we,
	input  logic [SW-1:0]        wgrp,
	input  logic [31:0]          wbl,
	input  logic [31:0]          wnx
);

	logic [SW-1:0]     grp_mem [SHARDS];
	logic [31:0]       bl_mem  [SHARDS];
	logic [31:0]       nx_mem  [SHARDS];
	logic [SHARDS-1:0] vg_q;
	logic [SHARDS-1:0] vc_q;
	logic [SW-1:0]     grp_q;
	logic [31:0]       bl_q;
	logic [31:0]       nx_q;
	logic              vg_rd_q;
	logic              vc_rd_q;

	// Write fields, register the read
	always_ff @(posedge clk) begin
		if (we.grp) begin
			grp_mem[waddr] <= wgrp;
		end
		if (we.cnt) begin
			bl_mem[waddr] <= wbl;
			nx_mem[waddr] <= wnx;
		end
		grp_q <= grp_mem[raddr];
		bl_q  <= bl_mem[raddr];
		nx_q  <= nx_mem[raddr];
	end

	// Track written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vg_q    <= '0;
			vc_q    <= '0;
			vg_rd_q <= 1'b0;
			vc_rd_q <= 1'b0;
		end else begin
			if (we.grp) begin
				vg_q[waddr] <= 1'b1;
			end
			if (we.cnt) begin
				vc_q[waddr] <= 1'b1;
			end
			vg_rd_q <= vg_q[raddr];
			vc_rd_q <= vc_q[raddr];
		end
	end

	assign rgrp = vg_rd_q ? grp_q : '0;
	assign rbl  = vc_rd_q ? bl_q : '0;
	assign rnx  = vc_rd_q ? nx_q : '0;

endmodule

// File: hw/rtl/bgus_group_mem.sv
// Group table: turn counter, upload and change times, lock per group.
module bgus_group_mem #(
	parameter int SHARDS = 16,
	parameter int SW = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SW-1:0]    raddr,
	output logic [31:0]      rturn,
	output logic [31:0]      rlu,
	output logic [31:0]      rlc,
	output logic             rlock,
	input  logic [SW-1:0]    waddr,
	input  bgus_pkg::gm_we_t we,
	input  logic [31:0]      wturn,
	input  logic [31:0]      wlu,
	input  logic [31:0]      wlc,
	input  logic             wlock
);

	logic [31:0]       turn_mem [SHARDS];
	logic [31:0]       lu_mem   [SHARDS];
	logic [31:0]       lc_mem   [SHARDS];
	logic [SHARDS-1:0] lock_q;
	logic [SHARDS-1:0] vt_q;
	logic [SHARDS-1:0] vu_q;
	logic [SHARDS-1:0] vl_q;
	logic [31:0]       turn_q;
	logic [31:0]       lu_q;
	logic [31:0]       lc_q;
	logic              lock_rd_q;
	logic              vt_rd_q;
	logic              vu_rd_q;
	logic              vl_rd_q;

	// Write fields, register the read
	always_ff @(posedge clk) begin
		if (we.turn) begin
			turn_mem[waddr] <= wturn;
		end
		if (we.lu) begin
			lu_mem[waddr] <= wlu;
		end
		if (we.lc) begin
			lc_mem[waddr] <= wlc;
		end
		turn_q <= turn_mem[raddr];
		lu_q   <= lu_mem[raddr];
		lc_q   <= lc_mem[raddr];
	end

	// Lock bits and written marks clear on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q    <= '0;
			vt_q      <= '0;
			vu_q      <= '0;
			vl_q      <= '0;
			lock_rd_q <= 1'b0;
			vt_rd_q   <= 1'b0;
			vu_rd_q   <= 1'b0;
			vl_rd_q   <= 1'b0;
		end else begin
			if (we.lock) begin
				lock_q[waddr] <= wlock;
			end
			if (we.turn) begin
				vt_q[waddr] <= 1'b1;
			end
			if (we.lu) begin
				vu_q[waddr] <= 1'b1;
			end
			if (we.lc) begin
				vl_q[waddr] <= 1'b1;
			end
			lock_rd_q <= lock_q[raddr];
			vt_rd_q   <= vt_q[raddr];
			vu_rd_q   <= vu_q[raddr];
			vl_rd_q   <= vl_q[raddr];
		end
	end

	assign rturn = vt_rd_q ? turn_q : '0;
	assign rlu   = vu_rd_q ? lu_q : '0;
	assign rlc   = vl_rd_q ? lc_q : '0;
	assign rlock = lock_rd_q;

endmodule

// File: hw/rtl/bgus_mod.sv
// Bit-serial remainder of the turn counter by the group size.
module bgus_mod #(
	parameter int DW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] rem
);

	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [31:0]   dvd_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   shifted;
	logic [DW:0]   reduced;

	// One quotient bit per cycle
	always_comb begin
		shifted = {rem_q, dvd_q[31]};
		reduced = (shifted >= {1'b0, divisor}) ? shifted - {1'b0, divisor} : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= reduced[DW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: hw/rtl/buddy_group_upload_scheduler.sv
// Buddy group upload scheduler: sequencer over the shard and group tables.
// One item at a time: an item takes two passes over the shard table through its single
// read port (one gathering the group's size, position, next-stage sums and buddy, one
// gathering backlog, member mask and group count after any change), a group rewrite of each
// shard that changes group on a split or merge, one more group-table write on a split, and
// the 32-step serial remainder of the turn counter. It takes longer while a finished result
// waits for the receiver.
// Both tables come out of reset cleared through per-entry written marks; no clearing pass.
// A finished result waits in the output register while the next item is taken.
module buddy_group_upload_scheduler #(
	parameter int SHARDS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// shard[3:0], now[35:4], backlog_bytes[67:36], nxt_bytes[99:68], zero fill
	input  logic [103:0] s_tdata,
	// func[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// group[3:0], group_members[19:4], grp_sum[55:20], did_split[56],
	// did_merge[57], active_groups[62:58], zero fill
	output logic [63:0]  m_tdata,
	// action[1:0]
	output logic [1:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int SW  = (SHARDS > 1) ? $clog2(SHARDS) : 1;
	localparam int CW  = $clog2(SHARDS + 1);
	localparam int NXW = 32 + CW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LD, ST_G, ST_WA, ST_DIV, ST_DEC, ST_W2, ST_SW, ST_WC, ST_FIN
	} state_t;

	state_t st_q;

	// Configuration
	logic [31:0] max_q;
	logic [15:0] ui_q;

	// Item
	logic [1:0]  func_q;
	logic [3:0]  shard_q;
	logic [31:0] tnow_q;
	logic [31:0] bl_in_q;
	logic [31:0] nx_in_q;
	logic        vsh_q;
	logic [SW-1:0] g_q;

	// Group entry of this item
	logic [31:0] turn_q;
	logic [31:0] lu_q;
	logic [31:0] lc_q;
	logic        lock_q;

	// First pass
	logic [CW-1:0]  size_q;
	logic [CW-1:0]  pos_q;
	logic [NXW-1:0] nx_q;
	logic           in_g_q;
	logic           bf_q;
	logic           in_b_q;
	logic [SW-1:0]  b_q;
	logic [CW-1:0]  bsize_q;
	logic           bnz_q;
	logic           first_q;
	logic [NXW-1:0] prod_q;

	// Decision
	logic turn_ok_q;
	logic split_q;
	logic merge_q;

	// Group rewrite range
	logic [CW-1:0] sw_ptr_q;
	logic [CW-1:0] sw_end_q;
	logic [SW-1:0] sw_grp_q;

	// Second pass
	logic [35:0]   bytes_q;
	logic [15:0]   mask_q;
	logic [CW-1:0] act_q;
	logic [SW-1:0] prevg_q;

	// Walk pipeline
	logic [CW-1:0] ic_q;
	logic          v_s1;
	logic [SW-1:0] idx_s1;

	// Output register
	logic        m_tvalid_q;
	logic [1:0]  o_action_q;
	logic [3:0]  o_group_q;
	logic [15:0] o_mask_q;
	logic [35:0] o_bytes_q;
	logic        o_split_q;
	logic        o_merge_q;
	logic [4:0]  o_active_q;

	// Memory ports
	logic [SW-1:0]    sm_raddr;
	logic [SW-1:0]    sm_rgrp;
	logic [31:0]      sm_rbl;
	logic [31:0]      sm_rnx;
	logic [SW-1:0]    sm_waddr;
	bgus_pkg::sm_we_t sm_we;
	logic [SW-1:0]    sm_wgrp;
	logic [SW-1:0]    gm_raddr;
	logic [31:0]      gm_rturn;
	logic [31:0]      gm_rlu;
	logic [31:0]      gm_rlc;
	logic             gm_rlock;
	logic [SW-1:0]    gm_waddr;
	bgus_pkg::gm_we_t gm_we;
	logic [31:0]      gm_wturn;
	logic [31:0]      gm_wlu;
	logic [31:0]      gm_wlc;
	logic             gm_wlock;

	logic          mod_start;
	logic          mod_done;
	logic [CW-1:0] mod_rem;

	logic          accept;
	logic          walking;
	logic          walk_done;
	logic          match;
	logic          out_free;
	logic          s_vsh;
	logic          cool;
	logic          nx_big;
	logic          turn_ok;
	logic [CW-1:0] half;
	logic [SW-1:0] g_half;
	logic [31:0]   bytes_lo;
	logic          grant;
	logic          in_window;

	assign s_tready  = (st_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_vsh     = (32'(s_tdata[3:0]) < SHARDS);
	assign walking   = (st_q == ST_WA) || (st_q == ST_WC);
	assign walk_done = (ic_q == CW'(SHARDS)) && !v_s1;
	assign match     = (sm_rgrp == g_q);

	// Decision terms
	assign turn_ok = (mod_rem == pos_q);
	assign cool    = (tnow_q - lc_q) >= {15'd0, ui_q, 1'b0};
	assign nx_big  = {1'b0, nx_q} > {prod_q, 1'b0};
	assign half    = size_q >> 1;
	assign g_half  = SW'(CW'(g_q) + half);
	assign bytes_lo = bytes_q[31:0];
	assign in_window = (tnow_q - lu_q) <= {16'd0, ui_q};
	assign grant   = !((bytes_q == 36'd0) ||
		((bytes_q[35:32] == 4'd0) && (bytes_lo < max_q) && in_window) || lock_q);

	bgus_shard_mem #(.SHARDS(SHARDS), .SW(SW)) u_smem (
		.clk(clk), .arst_n(arst_n),
		.raddr(sm_raddr), .rgrp(sm_rgrp), .rbl(sm_rbl), .rnx(sm_rnx),
		.waddr(sm_waddr), .we(sm_we), .wgrp(sm_wgrp), .wbl(bl_in_q), .wnx(nx_in_q)
	);

	bgus_group_mem #(.SHARDS(SHARDS), .SW(SW)) u_gmem (
		.clk(clk), .arst_n(arst_n),
		.raddr(gm_raddr), .rturn(gm_rturn), .rlu(gm_rlu), .rlc(gm_rlc), .rlock(gm_rlock),
		.waddr(gm_waddr), .we(gm_we), .wturn(gm_wturn), .wlu(gm_wlu), .wlc(gm_wlc),
		.wlock(gm_wlock)
	);

	bgus_mod #(.DW(CW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(turn_q),
		.divisor(size_q), .done(mod_done), .rem(mod_rem)
	);

	assign mod_start = (st_q == ST_WA) && walk_done;

	// Shard table addressing and writes
	always_comb begin
		sm_raddr = ic_q[SW-1:0];
		sm_waddr = SW'(shard_q);
		sm_we    = '0;
		sm_wgrp  = sw_grp_q;
		if (st_q == ST_LD) begin
			sm_raddr = SW'(shard_q);
		end
		if (st_q == ST_G && vsh_q && func_q == bgus_pkg::FN_REPORT) begin
			sm_we.cnt = 1'b1;
		end
		if (st_q == ST_SW) begin
			sm_waddr  = sw_ptr_q[SW-1:0];
			sm_we.grp = 1'b1;
		end
	end

	// Group table addressing and writes
	always_comb begin
		gm_raddr = g_q;
		gm_waddr = g_q;
		gm_we    = '0;
		gm_wturn = '0;
		gm_wlu   = tnow_q;
		gm_wlc   = tnow_q;
		gm_wlock = 1'b0;
		if (st_q == ST_G) begin
			gm_raddr = vsh_q ? sm_rgrp : '0;
		end
		unique case (st_q)
			ST_DEC: begin
				if (vsh_q && func_q == bgus_pkg::FN_DONE) begin
					gm_we.lu = 1'b1;
					if (lock_q) begin
						gm_we.turn = 1'b1;
						gm_we.lock = 1'b1;
						gm_wturn   = turn_q + 32'd1;
					end
				end else if (vsh_q && func_q == bgus_pkg::FN_TICK && turn_ok &&
						pos_q == '0 && cool) begin
					if (size_q > CW'(1) && nx_big) begin
						gm_waddr   = g_half;
						gm_we.turn = 1'b1;
						gm_we.lu   = 1'b1;
						gm_we.lc   = 1'b1;
					end else if (nx_q == '0 && bf_q && !bnz_q && b_q != g_q) begin
						gm_we.turn = 1'b1;
						gm_we.lc   = 1'b1;
					end
				end
			end
			ST_W2: begin
				gm_we.lc = 1'b1;
			end
			ST_FIN: begin
				if (out_free && vsh_q && func_q == bgus_pkg::FN_TICK && turn_ok_q && grant) begin
					gm_we.lock = 1'b1;
					gm_wlock   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= bgus_pkg::MAX_BUF_RESET;
			ui_q  <= bgus_pkg::INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == bgus_pkg::REG_MAX_BUF) begin
				max_q <= cfg_data;
			end else begin
				ui_q <= cfg_data[15:0];
			end
		end
	end

	// Sequencer: state, walk pipeline, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			ic_q       <= '0;
			v_s1       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// raise the result beat when finished, drop it once taken
			if (st_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// advance the walk
			v_s1 <= walking && (ic_q < CW'(SHARDS));
			if (walking && ic_q < CW'(SHARDS)) begin
				ic_q <= ic_q + CW'(1);
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_LD;
					end
				end
				ST_LD: st_q <= ST_G;
				ST_G: begin
					ic_q <= '0;
					st_q <= ST_WA;
				end
				ST_WA: begin
					if (walk_done) begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (mod_done) begin
						st_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					ic_q <= '0;
					if (vsh_q && func_q == bgus_pkg::FN_TICK && turn_ok && pos_q == '0 && cool &&
							size_q > CW'(1) && nx_big) begin
						st_q <= ST_W2;
					end else if (vsh_q && func_q == bgus_pkg::FN_TICK && turn_ok &&
							pos_q == '0 && cool &&
							nx_q == '0 && bf_q && !bnz_q && b_q != g_q) begin
						st_q <= ST_SW;
					end else begin
						st_q <= ST_WC;
					end
				end
				ST_W2: st_q <= ST_SW;
				ST_SW: begin
					ic_q <= '0;
					if (sw_ptr_q + CW'(1) == sw_end_q) begin
						st_q <= ST_WC;
					end
				end
				ST_WC: begin
					if (walk_done) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= ic_q[SW-1:0];
		prod_q <= NXW'(max_q * size_q);
		if (accept) begin
			func_q  <= s_tuser;
			shard_q <= s_tdata[3:0];
			tnow_q  <= s_tdata[35:4];
			bl_in_q <= s_tdata[67:36];
			nx_in_q <= s_tdata[99:68];
			vsh_q   <= s_vsh;
		end
		unique case (st_q)
			ST_G: begin
				g_q     <= vsh_q ? sm_rgrp : '0;
				size_q  <= '0;
				pos_q   <= '0;
				nx_q    <= '0;
				in_g_q  <= 1'b0;
				bf_q    <= 1'b0;
				in_b_q  <= 1'b0;
				b_q     <= '0;
				bsize_q <= '0;
				bnz_q   <= 1'b0;
				first_q <= 1'b1;
			end
			ST_WA: begin
				first_q <= 1'b0;
				if (first_q) begin
					turn_q <= gm_rturn;
					lu_q   <= gm_rlu;
					lc_q   <= gm_rlc;
					lock_q <= gm_rlock;
				end
				// gather size, position, next-stage sums and the buddy run
				if (v_s1) begin
					in_g_q <= match;
					if (match) begin
						size_q <= size_q + CW'(1);
						if (32'(idx_s1) < 32'(shard_q)) begin
							pos_q <= pos_q + CW'(1);
						end
						nx_q <= nx_q + NXW'(sm_rnx);
					end else if (in_g_q && !bf_q) begin
						bf_q    <= 1'b1;
						b_q     <= sm_rgrp;
						bsize_q <= CW'(1);
						bnz_q   <= |sm_rnx;
						in_b_q  <= 1'b1;
					end else if (in_b_q && sm_rgrp == b_q) begin
						bsize_q <= bsize_q + CW'(1);
						bnz_q   <= bnz_q | (|sm_rnx);
					end else begin
						in_b_q <= 1'b0;
					end
				end
			end
			ST_DEC: begin
				turn_ok_q <= turn_ok;
				split_q   <= 1'b0;
				merge_q   <= 1'b0;
				if (vsh_q && func_q == bgus_pkg::FN_TICK && turn_ok && pos_q == '0 && cool) begin
					if (size_q > CW'(1) && nx_big) begin
						split_q  <= 1'b1;
						sw_ptr_q <= CW'(g_half);
						sw_end_q <= CW'(g_q) + size_q;
						sw_grp_q <= g_half;
					end else if (nx_q == '0 && bf_q && !bnz_q && b_q != g_q) begin
						merge_q  <= 1'b1;
						sw_ptr_q <= CW'(b_q);
						sw_end_q <= CW'(b_q) + bsize_q;
						sw_grp_q <= g_q;
					end
				end
				bytes_q <= '0;
				mask_q  <= '0;
				act_q   <= CW'(1);
				prevg_q <= '0;
			end
			ST_SW: begin
				sw_ptr_q <= sw_ptr_q + CW'(1);
			end
			ST_WC: begin
				// gather backlog, member mask and group boundaries
				if (v_s1) begin
					prevg_q <= sm_rgrp;
					if (idx_s1 != '0 && sm_rgrp != prevg_q) begin
						act_q <= act_q + CW'(1);
					end
					if (match) begin
						bytes_q <= bytes_q + 36'(sm_rbl);
						if (32'(idx_s1) < bgus_pkg::MASK_W) begin
							mask_q[4'(idx_s1)] <= 1'b1;
						end
					end
				end
			end
			ST_FIN: begin
				if (out_free) begin
					o_split_q  <= split_q;
					o_merge_q  <= merge_q;
					o_active_q <= 5'(act_q);
					if (!vsh_q) begin
						o_action_q <= (func_q == bgus_pkg::FN_TICK) ? bgus_pkg::ACT_SKIP
							: bgus_pkg::ACT_ACK;
						o_group_q  <= '0;
						o_mask_q   <= '0;
						o_bytes_q  <= '0;
					end else begin
						o_group_q <= 4'(g_q);
						o_mask_q  <= mask_q;
						o_bytes_q <= bytes_q;
						if (func_q != bgus_pkg::FN_TICK) begin
							o_action_q <= bgus_pkg::ACT_ACK;
						end else if (!turn_ok_q) begin
							o_action_q <= bgus_pkg::ACT_SKIP;
						end else if (grant) begin
							o_action_q <= bgus_pkg::ACT_UPLOAD;
						end else begin
							o_action_q <= bgus_pkg::ACT_WAIT;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = o_action_q;
	assign m_tdata  = {1'b0, o_active_q, o_merge_q, o_split_q, o_bytes_q, o_mask_q, o_group_q};

	// A split or merge happens only on a tick that got its turn
	a_change_on_turn: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[56] || m_tdata[57]) |->
		(m_tuser == bgus_pkg::ACT_WAIT || m_tuser == bgus_pkg::ACT_UPLOAD))
		else $error("group change reported without a turn");

	// Never split and merge in one item
	a_one_change: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FIN |-> !(split_q && merge_q))
		else $error("split and merge together");

	// Remainder is in range of a nonempty group
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DEC |-> (size_q != '0) && (mod_rem < size_q))
		else $error("turn remainder out of range");

	// Group rewrite stays inside its range
	a_sw_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_SW |-> (sw_ptr_q < sw_end_q) && (sw_end_q <= CW'(SHARDS)))
		else $error("group rewrite out of range");

endmodule

// File: sim/buddy_group_upload_scheduler_test.sv
// Self-checking testbench of the buddy group upload scheduler.
`timescale 1ns / 1ps

// Expected reply of one item, laid out as {m_tuser, m_tdata[62:0]}
typedef struct packed {
	logic [1:0]  action;
	logic [4:0]  active;
	logic        merge;
	logic        split;
	logic [35:0] bytes;
	logic [15:0] members;
	logic [3:0]  group;
} reply_t;

// Scheduler state mirror and queue of expected replies
class sched_scoreboard;
	logic [3:0]  grp_of [16];
	logic [31:0] backlog [16];
	logic [31:0] next_stg [16];
	logic [31:0] turn [16];
	logic [31:0] last_up [16];
	logic [31:0] last_chg [16];
	logic        locked [16];
	logic [31:0] max_buf;
	logic [31:0] interval;
	reply_t      pending [$];
	int          errors;

	function void clear();
		for (int i = 0; i < 16; i++) begin
			grp_of[i] = 0; backlog[i] = 0; next_stg[i] = 0; turn[i] = 0;
			last_up[i] = 0; last_chg[i] = 0; locked[i] = 0;
		end
		max_buf = bgus_pkg::MAX_BUF_RESET;
		interval = {16'd0, bgus_pkg::INTERVAL_RESET};
		pending.delete();
		errors = 0;
	endfunction

	function void write_reg(logic idx, logic [31:0] val);
		if (idx == bgus_pkg::REG_MAX_BUF) max_buf = val;
		else interval = {16'd0, val[15:0]};
	endfunction

	function logic [35:0] group_backlog(logic [3:0] g);
		logic [35:0] s;
		s = 0;
		for (int i = 0; i < 16; i++) if (grp_of[i] == g) s += backlog[i];
		return s;
	endfunction

	function logic [63:0] group_next(logic [3:0] g);
		logic [63:0] s;
		s = 0;
		for (int i = 0; i < 16; i++) if (grp_of[i] == g) s += next_stg[i];
		return s;
	endfunction

	// Note one accepted item and queue its reply
	function void note_item(logic [1:0] fn, logic [3:0] sh, logic [31:0] now,
			logic [31:0] bl, logic [31:0] ns);
		reply_t r;
		logic [3:0] g, b, ng;
		int size, pos, last, k, half;
		logic [63:0] nx, thr;
		logic [35:0] by;
		r = '0;
		r.action = bgus_pkg::ACT_ACK;
		g = grp_of[sh];
		if (fn == bgus_pkg::FN_REPORT) begin
			backlog[sh] = bl; next_stg[sh] = ns;
		end else if (fn == bgus_pkg::FN_DONE) begin
			last_up[g] = now;
			if (locked[g]) begin
				turn[g] = turn[g] + 1; locked[g] = 0;
			end
		end else if (fn == bgus_pkg::FN_TICK) begin
			size = 0; pos = 0; last = 0;
			for (int i = 0; i < 16; i++) if (grp_of[i] == g) begin
				size++; last = i;
				if (i < sh) pos++;
			end
			if (turn[g] % size != pos) r.action = bgus_pkg::ACT_SKIP;
			else begin
				if (pos == 0 && (now - last_chg[g]) >= 2 * interval) begin
					nx = group_next(g);
					thr = 64'(max_buf) * 2 * size;
					if (size > 1 && nx > thr) begin
						half = size / 2; k = 0; ng = 0;
						for (int i = 0; i < 16; i++) if (grp_of[i] == g) begin
							if (k == half) ng = 4'(i);
							if (k >= half) grp_of[i] = ng;
							k++;
						end
						turn[ng] = 0; last_up[ng] = now; last_chg[ng] = now;
						last_chg[g] = now;
						r.split = 1;
					end else if (nx == 0 && last < 15) begin
						b = grp_of[last + 1];
						if (group_next(b) == 0 && b != g) begin
							for (int i = 0; i < 16; i++) if (grp_of[i] == b) grp_of[i] = g;
							turn[g] = 0; last_chg[g] = now;
							r.merge = 1;
						end
					end
				end
				by = group_backlog(g);
				if (by == 0 || (by < max_buf && (now - last_up[g]) <= interval)
						|| locked[g])
					r.action = bgus_pkg::ACT_WAIT;
				else begin
					locked[g] = 1; r.action = bgus_pkg::ACT_UPLOAD;
				end
			end
		end
		g = grp_of[sh];
		r.group = g;
		for (int i = 0; i < 16; i++) if (grp_of[i] == g) r.members[i] = 1;
		r.bytes = group_backlog(g);
		r.active = 1;
		for (int i = 1; i < 16; i++) if (grp_of[i] != grp_of[i - 1]) r.active++;
		pending.insert(pending.size(), r);
	endfunction

	// Compare one accepted reply with the oldest expectation
	function void check_reply(reply_t got);
		reply_t want;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected reply %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10) $display("reply mismatch: expected %h got %h", want, got);
		end
	endfunction
endclass

module buddy_group_upload_scheduler_test;
	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [31:0]  cfg_data;

	sched_scoreboard sb;
	int  send_idle;
	int  recv_idle;
	bit  hold_recv;
	int  quiet;
	bit  done;

	buddy_group_upload_scheduler dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Check every reply beat; count cycles with no beat
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_reply(reply_t'({m_tuser, m_tdata[62:0]}));
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	// Receiver with random stalls and one long hold-off
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 0;
		else m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
	end

	// Offer one beat; valid stays up after the accept until the next idle or drain
	task automatic send_item(logic [1:0] fn, logic [3:0] sh, logic [31:0] now,
			logic [31:0] bl, logic [31:0] ns);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= fn;
		s_tdata <= {4'd0, ns, bl, now, sh};
		do @(posedge clk); while (!s_tready);
		sb.note_item(fn, sh, now, bl, ns);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Mostly reports and ticks over a random clock, with completes and some reserved codes
	task automatic random_items(int count, logic [31:0] base);
		logic [31:0] now;
		int pick;
		now = base;
		for (int i = 0; i < count; i++) begin
			now += $urandom_range(600);
			pick = $urandom_range(9);
			if (pick < 3)
				send_item(bgus_pkg::FN_REPORT, 4'($urandom_range(15)), now,
					($urandom_range(3) == 0) ? 0 : $urandom,
					($urandom_range(2) == 0) ? 0 :
					($urandom_range(1) ? $urandom : $urandom_range(4000)));
			else if (pick < 8)
				send_item(bgus_pkg::FN_TICK, 4'($urandom_range(15)), now, $urandom, $urandom);
			else
				send_item(($urandom_range(7) == 0) ? bgus_pkg::FN_RSVD : bgus_pkg::FN_DONE,
					4'($urandom_range(15)), now, $urandom, $urandom);
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		send_idle = 10; recv_idle = 77; hold_recv = 0; done = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: done without lock, upload by backlog, split, merge, odd codes
		send_item(bgus_pkg::FN_DONE, 4'd0, 32'd0, 0, 0);
		send_item(bgus_pkg::FN_TICK, 4'd0, 32'd10, 0, 0);
		send_item(bgus_pkg::FN_REPORT, 4'd15, 32'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(bgus_pkg::FN_REPORT, 4'd3, 32'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(bgus_pkg::FN_TICK, 4'd5, 32'd30, 0, 0);
		send_item(bgus_pkg::FN_TICK, 4'd0, 32'd600, 0, 0);
		send_item(bgus_pkg::FN_TICK, 4'd8, 32'd610, 0, 0);
		send_item(bgus_pkg::FN_TICK, 4'd0, 32'd620, 0, 0);
		send_item(bgus_pkg::FN_DONE, 4'd2, 32'd630, 0, 0);
		send_item(bgus_pkg::FN_DONE, 4'd8, 32'd640, 0, 0);
		send_item(bgus_pkg::FN_REPORT, 4'd3, 32'd650, 0, 0);
		send_item(bgus_pkg::FN_REPORT, 4'd15, 32'd650, 32'd1, 0);
		send_item(bgus_pkg::FN_TICK, 4'd8, 32'd2000, 0, 0);
		send_item(bgus_pkg::FN_TICK, 4'd0, 32'd3000, 0, 0);
		send_item(bgus_pkg::FN_RSVD, 4'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(bgus_pkg::FN_TICK, 4'd0, 32'hFFFF_FFF0, 0, 0);
		send_item(bgus_pkg::FN_TICK, 4'd1, 32'd5, 0, 0);
		drain();

		// Phase 1: small thresholds, extremes of both registers along the way
		write_reg(bgus_pkg::REG_MAX_BUF, 32'd1);
		write_reg(bgus_pkg::REG_INTERVAL, 32'd1);
		random_items(150, 32'hFFFF_F000);
		drain();
		write_reg(bgus_pkg::REG_MAX_BUF, 32'hFFFF_FFFF);
		write_reg(bgus_pkg::REG_INTERVAL, 32'h0000_FFFF);
		random_items(150, 32'd0);
		drain();
		write_reg(bgus_pkg::REG_MAX_BUF, 32'd1000);
		write_reg(bgus_pkg::REG_INTERVAL, 32'd300);
		random_items(300, $urandom);

		// Long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_recv = 1;
				repeat (600) @(posedge clk);
				hold_recv = 0;
			end
			random_items(20, 32'd5000);
		join
		drain();

		send_idle = 77; recv_idle = 10;
		write_reg(bgus_pkg::REG_MAX_BUF, 32'h8000_0000);
		write_reg(bgus_pkg::REG_INTERVAL, 32'd100);
		random_items(350, $urandom);
		drain();

		send_idle = 0; recv_idle = 0;
		write_reg(bgus_pkg::REG_MAX_BUF, bgus_pkg::MAX_BUF_RESET);
		write_reg(bgus_pkg::REG_INTERVAL, {16'd0, bgus_pkg::INTERVAL_RESET});
		random_items(360, $urandom);
		drain();
		done = 1;
	end

	// End of run or watchdog
	initial begin
		@(posedge arst_n);
		while (!done && quiet < 20000) @(posedge clk);
		if (done && sb.errors == 0 && sb.pending.size() == 0)
			$display("buddy_group_upload_scheduler verification clean");
		else
			$display("buddy_group_upload_scheduler verification failed");
		$finish;
	end
endmodule

// File: files.f
hw/rtl/bgus_pkg.sv
hw/rtl/bgus_shard_mem.sv
hw/rtl/bgus_group_mem.sv
hw/rtl/bgus_mod.sv
hw/rtl/buddy_group_upload_scheduler.sv
sim/buddy_group_upload_scheduler_test.sv
